// ----- rtl/sm4_pkg.sv -----
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared types, constants and round functions of the SM4 block cipher:
// S-box, FK and CK constants, the data and key linear transforms.
// ----------------------------------------------------------------------------
package sm4_pkg;

	// number of cipher rounds and round keys
	localparam int ROUNDS = 32;
	localparam int CNT_W  = $clog2(ROUNDS);

	// configuration register indexes
	localparam int          CFG_IDX_W        = 2;
	localparam int          CFG_DATA_W       = 64;
	localparam logic [1:0]  REG_KEY_HIGH     = 2'd0;
	localparam logic [1:0]  REG_KEY_LOW      = 2'd1;
	localparam logic [1:0]  REG_DECRYPT_MODE = 2'd2;

	// payload of one input transaction
	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
	} sm4_in_t;

	// payload of one output transaction
	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} sm4_out_t;

	// system parameter FK
	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// byte-wise S-box substitution (tau)
	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
		return (w << n) | (w >> (32 - n));
	endfunction

	// data path transform T = L(tau(.))
	function automatic logic [31:0] data_mix(input logic [31:0] w);
		logic [31:0] b;
		b = sub_word(w);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	// key schedule transform T' = L'(tau(.))
	function automatic logic [31:0] key_mix(input logic [31:0] w);
		logic [31:0] b;
		b = sub_word(w);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// CK constant: byte j of word i is (4i + j) * 7 mod 256
	function automatic logic [31:0] ck_word(input logic [CNT_W-1:0] i);
		logic [31:0] w;
		logic [7:0]  n;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			n = 8'({i, 2'(j)});
			w = {w[23:0], 8'(n * 8'd7)};
		end
		return w;
	endfunction

endpackage

// ----- rtl/sm4_round.sv -----
// ----------------------------------------------------------------------------
// sm4_round
// One SM4 round: X[i+4] = X[i] ^ T(X[i+1] ^ X[i+2] ^ X[i+3] ^ rk), and the
// four-word state shifts by one word. Purely combinational.
// ----------------------------------------------------------------------------
module sm4_round
	import sm4_pkg::*;
(
	input  logic [127:0] x,
	input  logic [31:0]  rk,
	output logic [127:0] y
);

	logic [31:0] x0, x1, x2, x3;
	logic [31:0] nx;

	// word 0 sits in the top bits
	assign x0 = x[127:96];
	assign x1 = x[95:64];
	assign x2 = x[63:32];
	assign x3 = x[31:0];

	assign nx = x0 ^ data_mix(x1 ^ x2 ^ x3 ^ rk);
	assign y  = {x1, x2, x3, nx};

endmodule

// ----- rtl/sm4_key_exp.sv -----
// ----------------------------------------------------------------------------
// sm4_key_exp
// Key schedule engine. After reset or a start pulse it loads the key xor FK,
// then runs one key round per cycle, writing round key i into the store.
// Busy covers the load cycle and all key rounds.
// ----------------------------------------------------------------------------
module sm4_key_exp
	import sm4_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [127:0]               key,
	output logic                       busy,
	output logic [ROUNDS-1:0][31:0]    round_keys
);

	logic              load_q;
	logic              run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       k0_q, k1_q, k2_q, k3_q;
	logic [31:0]       nk;
	logic [ROUNDS-1:0][31:0] rk_q;

	// next round key
	assign nk = k0_q ^ key_mix(k1_q ^ k2_q ^ k3_q ^ ck_word(cnt_q));

	// sequencing: load, then count through the rounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b1;
			run_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			load_q <= 1'b1;
			run_q  <= 1'b0;
		end else if (load_q) begin
			load_q <= 1'b0;
			run_q  <= 1'b1;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROUNDS - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// key word shift register and round key store
	always_ff @(posedge clk) begin
		if (load_q) begin
			k0_q <= key[127:96] ^ FK0;
			k1_q <= key[95:64]  ^ FK1;
			k2_q <= key[63:32]  ^ FK2;
			k3_q <= key[31:0]   ^ FK3;
		end else if (run_q) begin
			k0_q        <= k1_q;
			k1_q        <= k2_q;
			k2_q        <= k3_q;
			k3_q        <= nk;
			rk_q[cnt_q] <= nk;
		end
	end

	assign busy       = load_q | run_q;
	assign round_keys = rk_q;

endmodule

// ----- rtl/sm4_block_cipher.sv -----
// ----------------------------------------------------------------------------
// sm4_block_cipher
// SM4 block cipher, 128-bit block and key, fully unrolled 32-stage round
// pipeline with an on-chip key schedule and encrypt / decrypt selection.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  block     | block_valid / block_ready  | block_data  (sm4_in_t)
//  result    | result_valid / result_ready| result_data (sm4_out_t)
//  config    | cfg_we                     | cfg_index, cfg_data
//
// One block per cycle sustained while the output is not stalled and the key
// schedule is idle. Each stage holds its own valid bit and loads whenever it
// is empty or the stage after it moves, so bubbles close up while the output
// stalls. After reset, and after every write to a key half, the key schedule
// runs its load and 32 key rounds; block_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module sm4_block_cipher
	import sm4_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   block_valid,
	output logic                   block_ready,
	input  sm4_in_t                block_data,
	output logic                   result_valid,
	input  logic                   result_ready,
	output sm4_out_t               result_data,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [63:0]              key_high_q;
	logic [63:0]              key_low_q;
	logic                     decrypt_q;
	logic                     key_start;
	logic                     key_busy;
	logic [ROUNDS-1:0][31:0]  round_keys;

	logic [ROUNDS:1]          valid_s;
	logic [127:0]             data_s [1:ROUNDS];
	logic [ROUNDS:1]          stage_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			decrypt_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HIGH:     key_high_q <= cfg_data;
				REG_KEY_LOW:      key_low_q  <= cfg_data;
				REG_DECRYPT_MODE: decrypt_q  <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	assign key_start = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	// key schedule
	sm4_key_exp u_key_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (key_start),
		.key        ({key_high_q, key_low_q}),
		.busy       (key_busy),
		.round_keys (round_keys)
	);

	// stage ready chain, from the output back
	assign stage_ready[ROUNDS] = !valid_s[ROUNDS] || result_ready;

	genvar g;
	generate
		for (g = 1; g < ROUNDS; g++) begin : g_rdy
			assign stage_ready[g] = !valid_s[g] || stage_ready[g+1];
		end

		// round pipeline: round g feeds stage g+1
		for (g = 0; g < ROUNDS; g++) begin : g_stage
			logic [127:0] rnd_in;
			logic [127:0] rnd_out;
			logic [31:0]  rk_sel;
			logic         prev_v;

			if (g == 0) begin : g_first
				assign rnd_in = {block_data.block_high, block_data.block_low};
				assign prev_v = block_valid && !key_busy;
			end else begin : g_next
				assign rnd_in = data_s[g];
				assign prev_v = valid_s[g];
			end

			// decryption walks the round keys backwards
			assign rk_sel = decrypt_q ? round_keys[ROUNDS-1-g] : round_keys[g];

			sm4_round u_round (
				.x  (rnd_in),
				.rk (rk_sel),
				.y  (rnd_out)
			);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g+1] <= 1'b0;
				end else if (stage_ready[g+1]) begin
					valid_s[g+1] <= prev_v;
				end
			end

			always_ff @(posedge clk) begin
				if (stage_ready[g+1] && prev_v) begin
					data_s[g+1] <= rnd_out;
				end
			end
		end
	endgenerate

	assign block_ready = stage_ready[1] && !key_busy;

	// output words in reverse order: X35, X34, X33, X32
	assign result_valid            = valid_s[ROUNDS];
	assign result_data.result_high = {data_s[ROUNDS][31:0], data_s[ROUNDS][63:32]};
	assign result_data.result_low  = {data_s[ROUNDS][95:64], data_s[ROUNDS][127:96]};

	// no block enters while the round keys are being rebuilt
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		key_busy |-> !block_ready)
		else $error("block ready during key expansion");

	// a key write always restarts the key schedule
	a_key_restart: assert property (@(posedge clk) disable iff (!arst_n)
		key_start |=> key_busy)
		else $error("key write did not start expansion");

	// an accepted block lands in the first stage
	a_first_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(block_valid && block_ready) |=> valid_s[1])
		else $error("accepted block lost at stage 1");

	// a full stage that cannot move keeps its item
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[1] && !stage_ready[1]) |=> (valid_s[1] && $stable(data_s[1])))
		else $error("stalled stage dropped or changed its item");

endmodule
